// ===== hw/rtl/smeu_pkg.sv =====
// Package for the stack machine execute unit: beat structs, action codes,
// status codes and the default stack depth. No dependencies.
package smeu_pkg;

  localparam int unsigned DefStackDepth = 64;

  typedef enum logic [3:0] {
    ACT_PUSH    = 4'd0,
    ACT_ADD     = 4'd1,
    ACT_SUB     = 4'd2,
    ACT_MUL     = 4'd3,
    ACT_DIV     = 4'd4,
    ACT_MOD     = 4'd5,
    ACT_EQUAL   = 4'd6,
    ACT_GREATER = 4'd7,
    ACT_DUP     = 4'd8,
    ACT_SWAP    = 4'd9,
    ACT_PRINT   = 4'd10
  } action_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNDER   = 2'd1,
    ST_OVER    = 2'd2,
    ST_DIVZERO = 2'd3
  } status_e;

  typedef struct packed {
    logic [3:0]         action;
    logic signed [31:0] push_value;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               print_valid;
    logic signed [31:0] print_data;
    logic [6:0]         depth_after;
  } out_beat_t;

  // Handshake between the sequencer and the divider.
  typedef struct packed {
    logic start;
    logic want_mod;
  } div_req_t;

endpackage

// ===== hw/rtl/smeu_div.sv =====
// Iterative signed 32-bit divider, one quotient bit per cycle.
// Depends on smeu_pkg for the request struct.
module smeu_div
  import smeu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  div_req_t    req_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] result_o
);

  logic [31:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic        busy_q, busy_d, negq_q, negq_d, negr_q, negr_d, mod_q, mod_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [32:0] trial;
  logic [31:0] rem_sh;

  // Shift-subtract step on magnitudes.
  always_comb begin
    rem_sh = {rem_q[30:0], quo_q[31]};
    trial  = {1'b0, rem_sh} - {1'b0, dvs_q};
    rem_d = rem_q; quo_d = quo_q; dvs_d = dvs_q; busy_d = busy_q;
    negq_d = negq_q; negr_d = negr_q; mod_d = mod_q; cnt_d = cnt_q;
    done_o = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 6'd32;
      rem_d  = '0;
      quo_d  = dividend_i[31] ? 32'(-dividend_i) : dividend_i;
      dvs_d  = divisor_i[31] ? 32'(-divisor_i) : divisor_i;
      negq_d = dividend_i[31] ^ divisor_i[31];
      negr_d = dividend_i[31];
      mod_d  = req_i.want_mod;
    end else if (busy_q) begin
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end else begin
        cnt_d = cnt_q - 6'd1;
        if (!trial[32]) begin
          rem_d = trial[31:0];
          quo_d = {quo_q[30:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          quo_d = {quo_q[30:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    if (mod_q) result_o = negr_q ? 32'(-rem_q) : rem_q;
    else       result_o = negq_q ? 32'(-quo_q) : quo_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; dvs_q <= dvs_d;
    negq_q <= negq_d; negr_q <= negr_d; mod_q <= mod_d;
  end

endmodule

// ===== hw/rtl/stack_machine_execute_unit.sv =====
// Top level of the stack machine execute unit: stack memory and sequencer.
// Depends on smeu_pkg and smeu_div.
//
//   channel | direction | signals
//   in      | input     | in_valid_i, in_ready_o, in_beat_i
//   out     | output    | out_valid_o, out_ready_i, out_beat_o
//
// One instruction at a time. Push, error cases and unused codes go straight to
// the done state; dup and print read the top entry, then execute; the others read
// both entries (synchronous reads of the stack memory), then the write-back; mul and
// swap also use the second write-back state. Div and mod wait in the one-bit-per-cycle divider.
// Reset empties the stack at once; no clearing pass is needed.
// A new beat is taken while the last result waits in the output register;
// the sequencer holds in its last state while a second result would stall.
module stack_machine_execute_unit
  import smeu_pkg::*;
#(
  parameter int unsigned StackDepth = DefStackDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_beat_o
);

  localparam int unsigned AW = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int unsigned SW = $clog2(StackDepth + 1);

  localparam logic [2:0] S_IDLE = 3'd0, S_RD1 = 3'd1, S_RD2 = 3'd2,
                         S_EXEC = 3'd3, S_DIV = 3'd4, S_WR2 = 3'd5, S_DONE = 3'd6;

  logic [31:0] mem_q [StackDepth];
  logic [31:0] rdata_q;
  logic [AW-1:0] raddr, waddr;
  logic          re, we;
  logic [31:0]   wdata;

  logic [2:0]  state_q, state_d;
  logic [SW-1:0] sp_q, sp_d;
  logic [3:0]  act_q, act_d;
  logic [31:0] val_q, val_d, top_q, top_d, sec_q, sec_d;
  logic [1:0]  stat_q, stat_d;
  logic        pv_q, pv_d;
  logic [31:0] pd_q, pd_d;
  out_beat_t   ob_q, ob_d;
  logic        ov_q, ov_d;

  div_req_t    dreq;
  logic        ddone;
  logic [31:0] dres;
  logic [31:0] prod;
  logic        stage_free;

  // The second entry is still on the read port when the divider starts.
  smeu_div u_div (
    .clk_i, .rst_ni, .req_i(dreq), .dividend_i(rdata_q), .divisor_i(top_q),
    .done_o(ddone), .result_o(dres)
  );

  // Stack memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (re) rdata_q <= mem_q[raddr];
  end

  assign prod       = top_q * sec_q;
  assign stage_free = !ov_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  // Sequencer: read operands, compute, write back, post the result.
  always_comb begin
    state_d = state_q; sp_d = sp_q; act_d = act_q; val_d = val_q;
    top_d = top_q; sec_d = sec_q; stat_d = stat_q; pv_d = pv_q; pd_d = pd_q;
    re = 1'b0; we = 1'b0; raddr = '0; waddr = '0; wdata = '0;
    dreq = '0;
    ob_d = ob_q; ov_d = ov_q;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d = in_beat_i.action;
          val_d = in_beat_i.push_value;
          stat_d = ST_OK; pv_d = 1'b0; pd_d = '0;
          state_d = S_DONE;
          case (in_beat_i.action)
            ACT_PUSH: begin
              if (sp_q >= SW'(StackDepth)) stat_d = ST_OVER;
              else begin
                we = 1'b1; waddr = AW'(sp_q); wdata = in_beat_i.push_value;
                sp_d = sp_q + SW'(1);
              end
            end
            ACT_DUP, ACT_PRINT: begin
              if (sp_q < SW'(1)) stat_d = ST_UNDER;
              else if (in_beat_i.action == ACT_DUP && sp_q >= SW'(StackDepth))
                stat_d = ST_OVER;
              else begin
                re = 1'b1; raddr = AW'(sp_q - SW'(1)); state_d = S_RD1;
              end
            end
            ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_MOD, ACT_EQUAL,
            ACT_GREATER, ACT_SWAP: begin
              if (sp_q < SW'(2)) stat_d = ST_UNDER;
              else begin
                re = 1'b1; raddr = AW'(sp_q - SW'(1)); state_d = S_RD1;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD1: begin
        // The top entry is on the read port now.
        top_d = rdata_q;
        if (act_q == ACT_DUP || act_q == ACT_PRINT) state_d = S_EXEC;
        else begin
          re = 1'b1; raddr = AW'(sp_q - SW'(2)); state_d = S_RD2;
        end
      end
      S_RD2: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_DONE;
        case (act_q)
          ACT_DUP: begin
            we = 1'b1; waddr = AW'(sp_q); wdata = rdata_q; sp_d = sp_q + SW'(1);
          end
          ACT_PRINT: begin
            pv_d = 1'b1; pd_d = rdata_q; sp_d = sp_q - SW'(1);
          end
          ACT_SWAP: begin
            sec_d = rdata_q;
            we = 1'b1; waddr = AW'(sp_q - SW'(2)); wdata = top_q;
            state_d = S_WR2;
          end
          ACT_DIV, ACT_MOD: begin
            sec_d = rdata_q;
            if (top_q == '0) stat_d = ST_DIVZERO;
            else begin
              dreq.start = 1'b1; dreq.want_mod = (act_q == ACT_MOD);
              state_d = S_DIV;
            end
          end
          default: begin
            we = 1'b1; waddr = AW'(sp_q - SW'(2)); sp_d = sp_q - SW'(1);
            case (act_q)
              ACT_ADD:   wdata = rdata_q + top_q;
              ACT_SUB:   wdata = rdata_q - top_q;
              ACT_EQUAL: wdata = {31'd0, rdata_q == top_q};
              ACT_GREATER: wdata = {31'd0, $signed(rdata_q) > $signed(top_q)};
              default: begin
                sec_d = rdata_q; we = 1'b0; sp_d = sp_q; state_d = S_WR2;
              end
            endcase
          end
        endcase
      end
      S_WR2: begin
        state_d = S_DONE;
        we = 1'b1;
        if (act_q == ACT_SWAP) begin
          waddr = AW'(sp_q - SW'(1)); wdata = sec_q;
        end else begin
          // Multiply: product of registered operands.
          waddr = AW'(sp_q - SW'(2)); wdata = prod; sp_d = sp_q - SW'(1);
        end
      end
      S_DIV: begin
        if (ddone) begin
          we = 1'b1; waddr = AW'(sp_q - SW'(2)); wdata = dres;
          sp_d = sp_q - SW'(1); state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (stage_free) begin
          ov_d = 1'b1;
          ob_d.status = stat_q; ob_d.print_valid = pv_q;
          ob_d.print_data = pd_q; ob_d.depth_after = 7'(sp_q);
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sp_q    <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      sp_q    <= sp_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d; val_q <= val_d; top_q <= top_d; sec_q <= sec_d;
    stat_q <= stat_d; pv_q <= pv_d; pd_q <= pd_d; ob_q <= ob_d;
  end

  assign out_valid_o = ov_q;
  assign out_beat_o  = ob_q;

endmodule

// ===== hw/rtl/smeu_checker.sv =====
// Port-level checker for the stack machine execute unit, bound to the top.
// Depends on smeu_pkg.
module smeu_checker
  import smeu_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_beat_t  in_beat_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_beat_t out_beat_o
);

  // A waiting result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_beat_o))
    else $error("output beat changed while stalled");

  // No print data without a print.
  a_pdata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_beat_o.print_valid |-> out_beat_o.print_data == '0)
    else $error("print data without print");

  // Print only reports ok.
  a_pstat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.print_valid |-> out_beat_o.status == ST_OK)
    else $error("print with error status");

  // An accepted beat is not followed by acceptance the next cycle.
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second beat taken too early");

endmodule

bind stack_machine_execute_unit smeu_checker u_smeu_checker (.*);

// ===== tb/smeu_checker.sv =====
// Checker for the stack machine execute unit: watches both channels, predicts
// each result beat from its own stack model and compares. Depends on smeu_pkg.
`timescale 1ns / 1ps
module smeu_scoreboard
  import smeu_pkg::*;
#(
  parameter int unsigned StackDepth = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_beat_t  in_beat_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_beat_t out_beat_i,
  output int        errors_o,
  output int        pending_o,
  output int        prints_o
);

  logic [31:0] stack_q [StackDepth];
  int unsigned depth_q;
  out_beat_t   results_q [$];

  function automatic logic [31:0] mag(logic [31:0] v);
    return v[31] ? -v : v;
  endfunction

  // Executes one instruction on the model stack and returns its result beat.
  function automatic out_beat_t execute(in_beat_t b);
    out_beat_t   r;
    logic [31:0] top, sec, res;
    logic        store;
    r = '0;
    r.status = ST_OK;
    store = 1'b0;
    res = '0;
    case (b.action)
      ACT_PUSH: begin
        if (depth_q >= StackDepth) r.status = ST_OVER;
        else begin
          stack_q[depth_q] = b.push_value;
          depth_q++;
        end
      end
      ACT_DUP: begin
        if (depth_q < 1) r.status = ST_UNDER;
        else if (depth_q >= StackDepth) r.status = ST_OVER;
        else begin
          stack_q[depth_q] = stack_q[depth_q-1];
          depth_q++;
        end
      end
      ACT_PRINT: begin
        if (depth_q < 1) r.status = ST_UNDER;
        else begin
          depth_q--;
          r.print_valid = 1'b1;
          r.print_data = stack_q[depth_q];
        end
      end
      ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_MOD, ACT_EQUAL, ACT_GREATER, ACT_SWAP: begin
        if (depth_q < 2) r.status = ST_UNDER;
        else begin
          top = stack_q[depth_q-1];
          sec = stack_q[depth_q-2];
          store = 1'b1;
          case (b.action)
            ACT_ADD: res = sec + top;
            ACT_SUB: res = sec - top;
            ACT_MUL: res = sec * top;
            ACT_DIV, ACT_MOD: begin
              if (top == 0) begin
                r.status = ST_DIVZERO;
                store = 1'b0;
              end else if (b.action == ACT_DIV) begin
                res = mag(sec) / mag(top);
                if (sec[31] ^ top[31]) res = -res;
              end else begin
                res = mag(sec) % mag(top);
                if (sec[31]) res = -res;
              end
            end
            ACT_EQUAL: res = {31'd0, sec == top};
            ACT_GREATER: res = {31'd0, $signed(sec) > $signed(top)};
            default: begin
              stack_q[depth_q-1] = sec;
              stack_q[depth_q-2] = top;
              store = 1'b0;
            end
          endcase
          if (store) begin
            stack_q[depth_q-2] = res;
            depth_q--;
          end
        end
      end
      default: ;
    endcase
    r.depth_after = 7'(depth_q);
    return r;
  endfunction

  assign pending_o = results_q.size();

  // Predict on each input beat, compare on each output beat.
  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t exp_b;
    if (!rst_ni) begin
      depth_q = 0;
      results_q.delete();
      errors_o <= 0;
      prints_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) results_q.push_back(execute(in_beat_i));
      if (out_valid_i && out_ready_i) begin
        if (out_beat_i.print_valid) prints_o <= prints_o + 1;
        if (results_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: %h", $time, out_beat_i);
          errors_o <= errors_o + 1;
        end else begin
          exp_b = results_q.pop_front();
          if (out_beat_i !== exp_b) begin
            $display("%0t: mismatch expected st=%0d pv=%0d pd=%h dep=%0d",
                     $time, exp_b.status, exp_b.print_valid, exp_b.print_data,
                     exp_b.depth_after);
            $display("%0t:          actual   st=%0d pv=%0d pd=%h dep=%0d",
                     $time, out_beat_i.status, out_beat_i.print_valid,
                     out_beat_i.print_data, out_beat_i.depth_after);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Testbench top for the stack machine execute unit: drives instruction beats
// with bursts and gaps, stalls the result side. Depends on smeu_pkg, smeu_scoreboard and the execute unit.
`timescale 1ns / 1ps
module testbench;
  import smeu_pkg::*;

  logic      clk, rst_n;
  logic      in_valid, in_ready, out_valid, out_ready;
  in_beat_t  in_beat;
  out_beat_t out_beat;
  int        errors, pending, prints;
  int        issued;
  int        model_depth;
  bit        hold_off;

  stack_machine_execute_unit i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_beat_i(in_beat),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_beat_o(out_beat)
  );

  smeu_scoreboard i_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_beat_i(in_beat),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_beat_i(out_beat),
    .errors_o(errors), .pending_o(pending), .prints_o(prints)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("testbench: errors");
    $finish;
  end

  // Receiver stall pattern; a long hold-off overrides it.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) out_ready <= 1'b0;
      else if (issued < 60 || issued > 500) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Long stall on the result side while instructions keep coming.
  initial begin
    hold_off = 1'b0;
    wait (issued == 200);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Sends one instruction beat and waits for acceptance. Valid stays high so
  // that the next beat can follow at once; the caller drops it before a gap.
  task automatic send(action_e act, logic [31:0] val);
    in_valid <= 1'b1;
    in_beat <= '{action: act, push_value: val};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    issued++;
  endtask

  // Drops valid after the last accepted beat, before any pause.
  task automatic stop_sending();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Sends a raw action code, including the unused ones.
  task automatic send_raw(logic [3:0] code, logic [31:0] val);
    send(action_e'(code), val);
  endtask

  function automatic logic [31:0] rnd_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'($urandom_range(0, 8));
      default: return $urandom();
    endcase
  endfunction

  // Picks an instruction biased toward keeping the stack usefully filled.
  task automatic send_random();
    int          k;
    logic [31:0] v;
    k = $urandom_range(0, 99);
    v = rnd_value();
    if (k < 3) send_raw(4'($urandom_range(11, 15)), v);
    else if (k < 35 && model_depth < 70) begin
      send(ACT_PUSH, v);
      if (model_depth < 64) model_depth++;
    end else if (k < 45) begin
      send(ACT_DUP, v);
      if (model_depth > 0 && model_depth < 64) model_depth++;
    end else if (k < 55) begin
      send(ACT_PRINT, v);
      if (model_depth > 0) model_depth--;
    end else if (k < 60) send(ACT_SWAP, v);
    else begin
      send(action_e'($urandom_range(ACT_ADD, ACT_GREATER)), v);
      if (model_depth > 1) model_depth--;
    end
  endtask

  initial begin
    int gap;
    int burst;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_beat = '0;
    issued = 0;
    model_depth = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: underflow on empty, every op, extremes, zero divisor.
    send(ACT_PRINT, 32'd0);
    send(ACT_ADD, 32'd0);
    send(ACT_DUP, 32'd0);
    send(ACT_PUSH, 32'h8000_0000);
    send(ACT_SWAP, 32'd0);
    send(ACT_PUSH, 32'hffff_ffff);
    send(ACT_DIV, 32'd0);
    send(ACT_PUSH, 32'h8000_0000);
    send(ACT_PUSH, 32'hffff_ffff);
    send(ACT_MOD, 32'd0);
    send(ACT_PUSH, 32'd0);
    send(ACT_DIV, 32'd0);
    send(ACT_MOD, 32'd0);
    send(ACT_PUSH, 32'h7fff_ffff);
    send(ACT_SWAP, 32'd0);
    send(ACT_GREATER, 32'd0);
    send(ACT_PUSH, 32'hffff_fff9);
    send(ACT_PUSH, 32'd2);
    send(ACT_MOD, 32'd0);
    send(ACT_EQUAL, 32'd0);
    send(ACT_PUSH, 32'h7fff_ffff);
    send(ACT_MUL, 32'd0);
    send(ACT_SUB, 32'd0);
    send_raw(4'd15, 32'h1234_5678);
    send(ACT_PRINT, 32'd0);
    stop_sending();
    wait (pending == 0);
    repeat (50) @(posedge clk);

    // Fill to overflow, then drain to empty.
    for (int i = 0; i < 66; i++) send(ACT_PUSH, $urandom());
    send(ACT_DUP, 32'd0);
    for (int i = 0; i < 65; i++) send(ACT_PRINT, 32'd0);
    model_depth = 0;

    // Random bursts with gaps.
    while (issued < 600) begin
      gap = $urandom_range(0, 3);
      burst = $urandom_range(1, 20);
      for (int i = 0; i < burst; i++) send_random();
      if (gap == 0) begin
        stop_sending();
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
      if (issued > 450 && issued < 470) begin
        stop_sending();
        wait (pending == 0);
      end
    end

    stop_sending();
    wait (pending == 0);
    repeat (50) @(posedge clk);
    $display("covered %0d instructions, %0d prints, overflow and underflow,", issued, prints);
    $display("zero divisors and a long result-side stall");
    if (errors == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule
